// ===== src/sorted_table_binary_search_assert.svh =====
// Assertion macros used by sorted_table_binary_search to check its own behaviour.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stbs_pkg.sv =====
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic probing;
    logic rd_en;
  } stbs_status_t;

endpackage

// ===== src/stbs_in_if.sv =====
`timescale 1ns / 1ps

interface stbs_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  stbs_pkg::idx_t    entry_index;
  stbs_pkg::key_t    key;

  modport source (output valid, output op, output entry_index, output key, input ready);
  modport sink (input valid, input op, input entry_index, input key, output ready);
endinterface

// ===== src/stbs_out_if.sv =====
`timescale 1ns / 1ps

interface stbs_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  stbs_pkg::idx_t    position;

  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

// ===== src/stbs_cfg_if.sv =====
`timescale 1ns / 1ps

interface stbs_cfg_if;
  logic              valid;
  logic              ready;
  stbs_pkg::cnt_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Payload                  | Transfer
// in_if    | sink      | op, entry_index, key     | valid && ready
// out_if   | source    | found, position          | valid && ready
// cfg_if   | sink      | data (entry_count)       | valid && ready, always ready
//
// A search makes P probes in S_PROBE, where P is at most
// floor(log2(min(entry_count, DEPTH))) + 1; 11 for 1024 keys, and then registers
// its result in S_FIN. The probe loop issues one read of the table memory's single
// read port per cycle. Reset clears the control state and entry_count; the table is
// not cleared. A stalled result holds the next search in S_FIN until its transfer completes.

`include "sorted_table_binary_search_assert.svh"

module sorted_table_binary_search #(
  parameter int DEPTH     = 1024,
  parameter int KEY_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  stbs_in_if.sink    in_if,
  stbs_out_if.source out_if,
  stbs_cfg_if.sink   cfg_if
);
  import stbs_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW  = $clog2(DEPTH + 1);
  localparam int HW  = (DW > CNT_W) ? DW : CNT_W;

  cnt_t         count_r;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  key_t         wr_data;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  key_t         rd_data;
  stbs_status_t status;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      count_r <= cfg_if.data;
    end
  end

  stbs_key_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stbs_search_seq #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES),
    .AW        (AW),
    .HW        (HW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .entry_count    (count_r),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_op          (in_if.op),
    .in_entry_index (in_if.entry_index),
    .in_key         (in_if.key),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_found      (out_if.found),
    .out_position   (out_if.position),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .status         (status)
  );

  `STBS_ASSERT_NEXT(a_read_feeds_probe, clk, rst_n, status.rd_en, status.probing, "table read issued without a probe to consume it")
  `STBS_ASSERT_NOW(a_miss_pos_zero, clk, rst_n, out_if.valid && !out_if.found, out_if.position == '0, "miss reported with a non-zero position")
  `STBS_ASSERT_NOW(a_hit_in_range, clk, rst_n, out_if.valid && out_if.found, CNT_W'(out_if.position) < count_r, "hit reported beyond the entries in use")
  `STBS_ASSERT_NOW(a_empty_no_probe, clk, rst_n, status.rd_en && !status.probing, count_r != '0, "probe started on an empty table")

endmodule

// ===== src/stbs_key_ram.sv =====
`timescale 1ns / 1ps

module stbs_key_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  stbs_pkg::key_t        wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output stbs_pkg::key_t        rd_data
);
  import stbs_pkg::*;

  key_t mem [DEPTH];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/stbs_search_seq.sv =====
`timescale 1ns / 1ps

module stbs_search_seq #(
  parameter int DEPTH     = 1024,
  parameter int KEY_BYTES = 4,
  parameter int AW        = 10,
  parameter int HW        = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stbs_pkg::cnt_t        entry_count,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  stbs_pkg::idx_t        in_entry_index,
  input  stbs_pkg::key_t        in_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output stbs_pkg::idx_t        out_position,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output stbs_pkg::key_t        wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  stbs_pkg::key_t        rd_data,
  output stbs_pkg::stbs_status_t status
);
  import stbs_pkg::*;

  localparam int CMP_W = (8 * KEY_BYTES < KEY_W) ? 8 * KEY_BYTES : KEY_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [HW-1:0]    lo_r, lo_nxt;
  logic [HW-1:0]    hi_r, hi_nxt;
  logic [HW-1:0]    mid_r, mid_nxt;
  logic [CMP_W-1:0] key_r, key_nxt;
  logic             hit_r, hit_nxt;
  idx_t             pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  idx_t             out_pos_r, out_pos_nxt;

  logic [HW-1:0]    count_ext;
  logic [HW-1:0]    hi_init;
  logic [HW-1:0]    half_init;
  logic [CMP_W-1:0] probe;
  logic             key_eq;
  logic             key_lt;
  logic [HW-1:0]    lo_step;
  logic [HW-1:0]    hi_step;
  logic [HW-1:0]    mid_step;
  logic             accept;

  assign count_ext = HW'(entry_count);
  assign hi_init   = (count_ext > HW'(DEPTH)) ? HW'(DEPTH) : count_ext;
  assign half_init = hi_init >> 1;

  // One probe per cycle: the registered read of the midpoint is compared,
  // and the next midpoint is sent to the table memory in the same cycle.
  assign probe    = rd_data[CMP_W-1:0];
  assign key_eq   = (key_r == probe);
  assign key_lt   = (key_r < probe);
  assign lo_step  = key_lt ? lo_r : mid_r + HW'(1);
  assign hi_step  = key_lt ? mid_r : hi_r;
  assign mid_step = lo_step + ((hi_step - lo_step) >> 1);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_data  = in_key;
  assign wr_addr  = AW'(in_entry_index);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = mid_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_WRITE) begin
          wr_en = (HW'(in_entry_index) < HW'(DEPTH));
        end else if (accept) begin
          key_nxt = in_key[CMP_W-1:0];
          lo_nxt  = '0;
          hi_nxt  = hi_init;
          mid_nxt = half_init;
          hit_nxt = 1'b0;
          pos_nxt = '0;
          if (hi_init != '0) begin
            rd_en     = 1'b1;
            rd_addr   = half_init[AW-1:0];
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_PROBE: begin
        if (key_eq) begin
          hit_nxt   = 1'b1;
          pos_nxt   = mid_r[IDX_W-1:0];
          state_nxt = S_FIN;
        end else if (lo_step < hi_step) begin
          lo_nxt  = lo_step;
          hi_nxt  = hi_step;
          mid_nxt = mid_step;
          rd_en   = 1'b1;
          rd_addr = mid_step[AW-1:0];
        end else begin
          hit_nxt   = 1'b0;
          pos_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_pos_nxt   = pos_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    hit_r       <= hit_nxt;
    pos_r       <= pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

  assign status.probing = (state_r == S_PROBE);
  assign status.rd_en   = rd_en;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 120;
  localparam int PLAN_ROWS      = 24;

  typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;

  typedef struct packed {
    logic found;
    idx_t position;
  } lookup_t;

  typedef struct packed {
    row_kind_t kind;
    logic      op;
    idx_t      idx;
    key_t      key;
    cnt_t      count;
    logic      typed;
    logic      found;
    idx_t      position;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();
  stbs_cfg_if cfg_ch ();

  sorted_table_binary_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  key_t        key_store [TABLE_DEPTH];
  cnt_t        live_count = '0;
  lookup_t     expected_lookups [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          hold_requests = 0;
  bit          sender_calm = 1'b0;
  bit          back_to_back = 1'b0;
  int unsigned boundary_sizes [13] = '{1, 2, 3, 7, 8, 15, 16, 31, 32, 63, 64, 127, 128};

  // Extremes, miss on an empty table, shrinking the count and an unsorted table.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0000, 11'd0, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h3FF, 32'hFFFF_FFFF, 11'd0, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_WRITE,  10'h000, 32'h0000_0000, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_WRITE,  10'h001, 32'h0000_0005, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_WRITE,  10'h002, 32'h8000_0000, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_WRITE,  10'h003, 32'hFFFF_FFFF, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_WRITE,  10'h3FF, 32'hFFFF_FFFF, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_COUNT, OP_WRITE,  10'h000, 32'h0000_0000, 11'd4, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h155, 32'h0000_0000, 11'd0, 1'b1, 1'b1, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h2AA, 32'hFFFF_FFFF, 11'd0, 1'b1, 1'b1, 10'd3},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0005, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0006, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h8000_0000, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h7FFF_FFFF, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_COUNT, OP_WRITE,  10'h000, 32'h0000_0000, 11'd1, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0000, 11'd0, 1'b1, 1'b1, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0005, 11'd0, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_WRITE,  10'h000, 32'hFFFF_FFFF, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_COUNT, OP_WRITE,  10'h000, 32'h0000_0000, 11'd4, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0000, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0005, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_COUNT, OP_WRITE,  10'h000, 32'h0000_0000, 11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h000, 32'h0000_0005, 11'd0, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM,  OP_SEARCH, 10'h3FF, 32'hFFFF_FFFF, 11'd0, 1'b1, 1'b0, 10'd0}
  };

  function automatic lookup_t predict_lookup(key_t want);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lookup_t     res;
    res = '0;
    lo = 0;
    hi = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
    while (lo < hi && !res.found) begin
      mid = lo + (hi - lo) / 2;
      if (key_store[mid] == want) begin
        res.found = 1'b1;
        res.position = idx_t'(mid);
      end else if (want < key_store[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
    mismatches++;
  endtask

  task automatic idle_after();
    int k;
    int r;
    r = $urandom_range(0, 99);
    if (back_to_back || sender_calm || r < 50) k = 0;
    else if (r < 85) k = $urandom_range(1, 3);
    else if (r < 97) k = $urandom_range(4, 10);
    else k = $urandom_range(20, 40);
    if (k > 0) begin
      in_ch.valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  task automatic offer(logic op, idx_t idx, key_t key, bit typed, lookup_t given);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.entry_index <= idx;
    in_ch.key         <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_WRITE) begin
      key_store[idx] = key;
    end else if (typed) begin
      expected_lookups.push_back(given);
    end else begin
      expected_lookups.push_back(predict_lookup(key));
    end
    items_sent++;
    idle_after();
  endtask

  // The count may only change while the block is idle, so every search is
  // drained first and a trailing write is given time to land.
  task automatic set_count(cnt_t value);
    in_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    live_count = value;
  endtask

  task automatic load_table(int n);
    int               style;
    int unsigned      span;
    longint unsigned  acc;
    key_t             k;
    style = $urandom_range(0, 9);
    acc = $urandom_range(0, 32'hFFFF_0000);
    case (style)
      0, 1: span = 2;
      2, 3: span = 300;
      4, 5, 6: begin
        span = (n == 1) ? 32'hFFFF_FFFF : (32'hFFFF_FFFF / n) * 2;
        acc = 0;
      end
      7: span = 1 << 20;
      9: begin
        span = 3;
        acc = 64'hFFFF_FFFF - 2 * n;
      end
      default: span = 0;
    endcase
    for (int i = 0; i < n; i++) begin
      if (style == 8) begin
        k = $urandom;
      end else begin
        k = acc[31:0];
        acc = acc + $urandom_range(0, span);
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
      offer(OP_WRITE, idx_t'(i), k, 1'b0, '0);
    end
  endtask

  task automatic run_ops(int n_ops);
    int   lim;
    int   r;
    int   i;
    idx_t idx;
    key_t k;
    lim = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      idx = idx_t'($urandom_range(0, TABLE_DEPTH - 1));
      if (r < 12) begin
        k = $urandom_range(0, 1) ? key_store[idx] : key_t'($urandom);
        offer(OP_WRITE, idx, k, 1'b0, '0);
      end else begin
        if (r < 62 && lim > 0) begin
          i = $urandom_range(0, lim - 1);
          k = key_store[i];
        end else if (r < 80 && lim > 0) begin
          i = $urandom_range(0, lim - 1);
          k = $urandom_range(0, 1) ? key_store[i] + 1 : key_store[i] - 1;
        end else if (r < 84) begin
          k = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        end else begin
          k = $urandom;
        end
        offer(OP_SEARCH, idx, k, 1'b0, '0);
      end
    end
  endtask

  initial begin
    int      base;
    int      phase_no;
    int      n;
    int      r;
    cnt_t    cnt;
    lookup_t given;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_WRITE;
    in_ch.entry_index <= '0;
    in_ch.key         <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_COUNT) begin
        set_count(directed_plan[i].count);
      end else begin
        given.found = directed_plan[i].found;
        given.position = directed_plan[i].position;
        offer(directed_plan[i].op, directed_plan[i].idx, directed_plan[i].key,
              directed_plan[i].typed, given);
      end
    end

    // A full table first, so that every entry has been written before any
    // later count lets a search reach it.
    load_table(TABLE_DEPTH);
    set_count(cnt_t'(TABLE_DEPTH));
    run_ops(60);
    set_count(11'd2047);
    run_ops(25);
    set_count(cnt_t'(TABLE_DEPTH + 1));
    run_ops(10);
    set_count(11'd0);
    run_ops(8);

    base = items_sent;
    phase_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 6) n = $urandom_range(1, 40);
      else if (r < 9) n = $urandom_range(41, 300);
      else n = boundary_sizes[$urandom_range(0, 12)];
      load_table(n);
      r = $urandom_range(0, 9);
      if (r == 0) cnt = '0;
      else if (r == 1) cnt = cnt_t'($urandom_range(0, TABLE_DEPTH));
      else cnt = cnt_t'(n);
      set_count(cnt);
      sender_calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 0 || phase_no == 6) begin
        hold_requests <= hold_requests + 1;
        back_to_back = 1'b1;
      end
      run_ops($urandom_range(25, 40));
      back_to_back = 1'b0;
      phase_no++;
    end

    in_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: checks each transfer and stalls at random. On request it
  // holds off for a long stretch so that the block backs up into its input.
  initial begin : receiver
    int      stall_left;
    int      holds_served;
    int      r;
    bit      rx_calm;
    lookup_t want;
    stall_left = 0;
    holds_served = 0;
    rx_calm = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          flag_mismatch("unexpected result", out_ch.position, 0);
        end else begin
          want = expected_lookups.pop_front();
          if (out_ch.found !== want.found)
            flag_mismatch("found", out_ch.found, want.found);
          if (out_ch.position !== want.position)
            flag_mismatch("position", out_ch.position, want.position);
        end
      end
      if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (rx_calm || r < 55) stall_left = 0;
        else if (r < 85) stall_left = $urandom_range(1, 3);
        else if (r < 97) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 60);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+src
src/stbs_pkg.sv
src/stbs_in_if.sv
src/stbs_out_if.sv
src/stbs_cfg_if.sv
src/stbs_key_ram.sv
src/stbs_search_seq.sv
src/sorted_table_binary_search.sv
test/testbench.sv
